// ----- rtl/room_mode_merge_table_assert.svh -----
// Assertion macros shared by the mode table RTL
`ifndef ROOM_MODE_MERGE_TABLE_ASSERT_SVH
`define ROOM_MODE_MERGE_TABLE_ASSERT_SVH

// expression must hold at every edge out of reset
`define RMMT_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RMMT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmmt_pkg.sv -----
`timescale 1ns / 1ps
package rmmt_pkg;

    localparam int FreqW = 23;
    localparam int StrW  = 16;
    localparam int SecW  = 32;
    localparam int HitW  = 16;
    localparam int EntW  = FreqW + StrW + SecW + HitW;
    localparam int NumW  = FreqW + 1;   // dividend width of rounded step
    localparam int DenW  = HitW + 1;    // hits + 1

    localparam logic [2:0] ActIgnored  = 3'd0;
    localparam logic [2:0] ActMerged   = 3'd1;
    localparam logic [2:0] ActInserted = 3'd2;
    localparam logic [2:0] ActReplaced = 3'd3;
    localparam logic [2:0] ActDropped  = 3'd4;
    localparam logic [2:0] ActCleared  = 3'd5;

    localparam logic OpReport = 1'b0;
    localparam logic OpClear  = 1'b1;

    localparam logic CfgCollect = 1'b0;
    localparam logic CfgTol     = 1'b1;
    localparam logic [15:0] TolReset = 16'd983;

    typedef struct packed {
        logic                    op;
        logic [FreqW-1:0]        tone_freq;
        logic signed [StrW-1:0]  tone_strength;
        logic [SecW-1:0]         tone_seconds;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]              action;
        logic [2:0]              slot;
        logic [FreqW-1:0]        entry_freq;
        logic signed [StrW-1:0]  entry_strength;
        logic [SecW-1:0]         entry_seconds;
        logic [HitW-1:0]         entry_hits;
        logic [3:0]              used_count;
    } t_out_beat;

    typedef struct packed {
        logic [FreqW-1:0]        freq;
        logic signed [StrW-1:0]  strength;
        logic [SecW-1:0]         seconds;
        logic [HitW-1:0]         hits;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_RD, S_CMP, S_DIV, S_WB, S_INS, S_FIN
    } t_state;

endpackage

// ----- rtl/rmmt_ram.sv -----
`timescale 1ns / 1ps
module rmmt_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                  i_wdata,
    input  logic                              i_re,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                  o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/room_mode_merge_table.sv -----
`timescale 1ns / 1ps
// Room mode table: merges tone reports into up to MAX_MODES resonance entries.
// Input channel (i_in_valid / o_in_ready, beat i_in): one report or clear op.
// Output channel (o_out_valid / i_out_ready, beat o_out): one result per op.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 collect enable, 1 merge tolerance Q0.16); the user writes it only while
// idle, which the block itself does not enforce. After an op is accepted, a
// clear or ignored report goes straight to the finish state, which loads the
// output register once it is free. A report first forms the tolerance window,
// then walks the table one entry at a time (memory read, then compare); a
// merge at an entry runs the bit-serial divider of the frequency step, then
// one write-back; insert/replace/drop follow a walk over all used entries.
// One op is in work at a time; the next is accepted once the result sits
// in the output register, even while that register still waits.
// If the receiver stalls, the result holds in the output register and a
// finished second op waits until the register frees.
// Reset empties the table (used count 0), turns collection off and sets
// the tolerance to 983; entry memory contents are not cleared.
`include "room_mode_merge_table_assert.svh"
module room_mode_merge_table #(
    parameter int MAX_MODES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmmt_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmmt_pkg::t_out_beat o_out
);
    localparam int IW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CW = $clog2(MAX_MODES + 1);
    localparam int WinW = 16 + rmmt_pkg::FreqW;
    localparam int DcW = $clog2(rmmt_pkg::NumW + 1);

    rmmt_pkg::t_state r_state, n_state;
    rmmt_pkg::t_in_beat r_in;
    rmmt_pkg::t_out_beat r_res;
    rmmt_pkg::t_entry r_ent, w_rd, w_wd;
    logic r_collect;
    logic [15:0] r_tol;
    logic [CW-1:0] r_used;
    logic [WinW-1:0] r_win;
    logic [IW-1:0] r_idx, r_minidx;
    logic [rmmt_pkg::SecW-1:0] r_min;
    logic [rmmt_pkg::NumW-1:0] r_num;
    logic [rmmt_pkg::DenW-1:0] r_den, r_rem;
    logic [DcW-1:0] r_dcnt;
    logic [rmmt_pkg::EntW-1:0] w_rdata;

    logic w_accept, w_last, w_match, w_full, w_repl_ok, w_we, w_re, w_out_free;
    logic [IW-1:0] w_waddr;
    logic [rmmt_pkg::FreqW-1:0] w_diff, w_newf;
    logic [rmmt_pkg::DenW-1:0] w_n;
    logic [rmmt_pkg::DenW:0] w_remt;
    logic [rmmt_pkg::SecW:0] w_secsum;

    assign w_rd = rmmt_pkg::t_entry'(w_rdata);
    assign o_in_ready = (r_state == rmmt_pkg::S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_full = (r_used == CW'(MAX_MODES));
    assign w_last = ((CW'(r_idx) + CW'(1)) == r_used);

    // compare of the entry being read
    assign w_diff = (w_rd.freq > r_in.tone_freq) ? w_rd.freq - r_in.tone_freq
                                                 : r_in.tone_freq - w_rd.freq;
    assign w_match = ({w_diff, 16'd0} < r_win);
    assign w_n = {1'b0, w_rd.hits} + rmmt_pkg::DenW'(1);

    // divider step: one quotient bit per cycle
    assign w_remt = {r_rem, r_num[rmmt_pkg::NumW-1]};

    // merge arithmetic
    assign w_newf = (r_in.tone_freq >= r_ent.freq)
                  ? r_ent.freq + r_num[rmmt_pkg::FreqW-1:0]
                  : r_ent.freq - r_num[rmmt_pkg::FreqW-1:0];
    assign w_secsum = {1'b0, r_ent.seconds} + {1'b0, r_in.tone_seconds};
    assign w_repl_ok = r_in.tone_seconds > r_min;

    // memory write selection
    always_comb begin
        w_we = 1'b0;
        w_waddr = r_idx;
        w_wd.freq = r_in.tone_freq;
        w_wd.strength = r_in.tone_strength;
        w_wd.seconds = r_in.tone_seconds;
        w_wd.hits = rmmt_pkg::HitW'(1);
        w_re = (r_state == rmmt_pkg::S_RD);
        case (r_state)
            rmmt_pkg::S_WB: begin
                w_we = 1'b1;
                w_wd.freq = w_newf;
                w_wd.strength = (r_in.tone_strength > r_ent.strength)
                              ? r_in.tone_strength : r_ent.strength;
                w_wd.seconds = w_secsum[rmmt_pkg::SecW] ? '1
                             : w_secsum[rmmt_pkg::SecW-1:0];
                w_wd.hits = (&r_ent.hits) ? r_ent.hits
                          : r_ent.hits + rmmt_pkg::HitW'(1);
            end
            rmmt_pkg::S_INS: begin
                w_we = !w_full || w_repl_ok;
                w_waddr = w_full ? r_minidx : IW'(r_used);
            end
            default: ;
        endcase
    end

    rmmt_ram #(.Width(rmmt_pkg::EntW), .Depth(MAX_MODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wd),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmmt_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in.op == rmmt_pkg::OpClear || !r_collect || i_in.tone_freq == '0)
                        n_state = rmmt_pkg::S_FIN;
                    else
                        n_state = rmmt_pkg::S_MUL;
                end
            end
            rmmt_pkg::S_MUL: n_state = (r_used == '0) ? rmmt_pkg::S_INS : rmmt_pkg::S_RD;
            rmmt_pkg::S_RD:  n_state = rmmt_pkg::S_CMP;
            rmmt_pkg::S_CMP: begin
                if (w_match) n_state = rmmt_pkg::S_DIV;
                else if (w_last) n_state = rmmt_pkg::S_INS;
                else n_state = rmmt_pkg::S_RD;
            end
            rmmt_pkg::S_DIV: begin
                if (r_dcnt == DcW'(rmmt_pkg::NumW - 1)) n_state = rmmt_pkg::S_WB;
            end
            rmmt_pkg::S_WB:  n_state = rmmt_pkg::S_FIN;
            rmmt_pkg::S_INS: n_state = rmmt_pkg::S_FIN;
            rmmt_pkg::S_FIN: if (w_out_free) n_state = rmmt_pkg::S_IDLE;
            default: n_state = rmmt_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmmt_pkg::S_IDLE;
            r_collect <= 1'b0;
            r_tol <= rmmt_pkg::TolReset;
            r_used <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == rmmt_pkg::CfgCollect) r_collect <= i_cfg_data[0];
                else r_tol <= i_cfg_data;
            end
            if (w_accept && i_in.op == rmmt_pkg::OpClear) r_used <= '0;
            if (r_state == rmmt_pkg::S_INS && !w_full) r_used <= r_used + CW'(1);
            if (r_state == rmmt_pkg::S_FIN && w_out_free) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rmmt_pkg::S_IDLE: begin
                r_in <= i_in;
                r_idx <= '0;
                r_res.action <= (i_in.op == rmmt_pkg::OpClear) ? rmmt_pkg::ActCleared
                                                               : rmmt_pkg::ActIgnored;
                r_res.slot <= '0;
                r_res.entry_freq <= '0;
                r_res.entry_strength <= '0;
                r_res.entry_seconds <= '0;
                r_res.entry_hits <= '0;
                r_res.used_count <= (i_in.op == rmmt_pkg::OpClear) ? 4'd0 : 4'(r_used);
            end
            rmmt_pkg::S_MUL: r_win <= WinW'(r_tol) * WinW'(r_in.tone_freq);
            rmmt_pkg::S_CMP: begin
                if (w_match) begin
                    r_ent <= w_rd;
                    r_num <= rmmt_pkg::NumW'({1'b0, w_diff} + rmmt_pkg::NumW'(w_n >> 1));
                    r_den <= w_n;
                    r_rem <= '0;
                    r_dcnt <= '0;
                end else begin
                    if (r_idx == '0 || w_rd.seconds < r_min) begin
                        r_min <= w_rd.seconds;
                        r_minidx <= r_idx;
                    end
                    if (!w_last) r_idx <= r_idx + IW'(1);
                end
            end
            rmmt_pkg::S_DIV: begin
                r_dcnt <= r_dcnt + DcW'(1);
                if (w_remt >= {1'b0, r_den}) begin
                    r_rem <= rmmt_pkg::DenW'(w_remt - {1'b0, r_den});
                    r_num <= {r_num[rmmt_pkg::NumW-2:0], 1'b1};
                end else begin
                    r_rem <= w_remt[rmmt_pkg::DenW-1:0];
                    r_num <= {r_num[rmmt_pkg::NumW-2:0], 1'b0};
                end
            end
            rmmt_pkg::S_WB: begin
                r_res.action <= rmmt_pkg::ActMerged;
                r_res.slot <= 3'(r_idx);
                r_res.entry_freq <= w_wd.freq;
                r_res.entry_strength <= w_wd.strength;
                r_res.entry_seconds <= w_wd.seconds;
                r_res.entry_hits <= w_wd.hits;
                r_res.used_count <= 4'(r_used);
            end
            rmmt_pkg::S_INS: begin
                if (w_we) begin
                    r_res.action <= w_full ? rmmt_pkg::ActReplaced : rmmt_pkg::ActInserted;
                    r_res.slot <= 3'(w_waddr);
                    r_res.entry_freq <= w_wd.freq;
                    r_res.entry_strength <= w_wd.strength;
                    r_res.entry_seconds <= w_wd.seconds;
                    r_res.entry_hits <= w_wd.hits;
                    r_res.used_count <= w_full ? 4'(r_used) : 4'(r_used + CW'(1));
                end else begin
                    r_res.action <= rmmt_pkg::ActDropped;
                    r_res.used_count <= 4'(r_used);
                end
            end
            rmmt_pkg::S_FIN: if (w_out_free) o_out <= r_res;
            default: ;
        endcase
    end

    `RMMT_ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= CW'(MAX_MODES), "used count over depth")
    `RMMT_ASSERT_IMPLY(a_we_state, i_clk, i_rst_n, w_we, r_state == rmmt_pkg::S_WB || r_state == rmmt_pkg::S_INS, "table write outside update")
    `RMMT_ASSERT_IMPLY(a_merge_hits, i_clk, i_rst_n, o_out_valid && o_out.action == rmmt_pkg::ActMerged, o_out.entry_hits != '0, "merged entry with zero hits")
endmodule
